/* rtl/core/cfe_pkg.sv */
// Shared types, codes and microcode table for the command frame encoder.
package cfe_pkg;

  localparam int unsigned PC_W = 5;
  typedef logic [PC_W-1:0] pc_t;

  localparam logic [2:0] CMD_VEL   = 3'd0;
  localparam logic [2:0] CMD_HAND  = 3'd1;
  localparam logic [2:0] CMD_ARM   = 3'd2;
  localparam logic [2:0] CMD_IK    = 3'd3;
  localparam logic [2:0] CMD_BEEP  = 3'd4;
  localparam logic [2:0] CMD_RESET = 3'd5;

  localparam logic [1:0] CFG_LIM_X = 2'd0;
  localparam logic [1:0] CFG_LIM_Y = 2'd1;
  localparam logic [1:0] CFG_LIM_W = 2'd2;

  localparam logic [14:0] LIM_X_RST = 15'd1500;
  localparam logic [14:0] LIM_Y_RST = 15'd1200;
  localparam logic [14:0] LIM_W_RST = 15'd6280;

  localparam logic [7:0] HDR0          = 8'hAA;
  localparam logic [7:0] HDR1          = 8'h55;
  localparam logic [7:0] ID_VEL        = 8'h50;
  localparam logic [7:0] ID_HAND       = 8'h60;
  localparam logic [7:0] ID_ARM        = 8'h70;
  localparam logic [7:0] ID_IK         = 8'h90;
  localparam logic [7:0] ID_BEEP       = 8'h66;
  localparam logic [7:0] ID_RESET      = 8'h6F;
  localparam logic [7:0] RESET_PAYLOAD = 8'd100;

  // byte source of a control word
  localparam logic [2:0] SRC_HDR0 = 3'd0;
  localparam logic [2:0] SRC_HDR1 = 3'd1;
  localparam logic [2:0] SRC_LEN  = 3'd2;
  localparam logic [2:0] SRC_ID   = 3'd3;
  localparam logic [2:0] SRC_WHI  = 3'd4;
  localparam logic [2:0] SRC_WLO  = 3'd5;
  localparam logic [2:0] SRC_RST  = 3'd6;
  localparam logic [2:0] SRC_SUM  = 3'd7;

  // sequencing of a control word
  localparam logic [1:0] MODE_SEQ      = 2'd0;
  localparam logic [1:0] MODE_DISPATCH = 2'd1;
  localparam logic [1:0] MODE_BRANCH   = 2'd2;
  localparam logic [1:0] MODE_JUMP     = 2'd3;

  localparam pc_t PC_START = 5'd0;
  localparam pc_t PC_WORDS = 5'd4;
  localparam pc_t PC_RST   = 5'd18;
  localparam pc_t PC_SUM   = 5'd19;

  typedef struct packed {
    logic [2:0] src;
    logic [2:0] widx;
    logic [1:0] mode;
    logic [2:0] cond;
    pc_t        target;
  } uop_t;

  typedef struct packed {
    logic [7:0] len;
    logic [7:0] id;
    logic [2:0] nwords;
    pc_t        entry;
  } cmd_info_t;

  function automatic cmd_info_t cmd_info(input logic [2:0] cmd);
    cmd_info_t r;
    unique case (cmd)
      CMD_VEL:   r = '{8'd11, ID_VEL,   3'd3, PC_WORDS};
      CMD_HAND:  r = '{8'd7,  ID_HAND,  3'd1, PC_WORDS};
      CMD_ARM:   r = '{8'd15, ID_ARM,   3'd5, PC_WORDS};
      CMD_IK:    r = '{8'd19, ID_IK,    3'd7, PC_WORDS};
      CMD_BEEP:  r = '{8'd11, ID_BEEP,  3'd3, PC_WORDS};
      CMD_RESET: r = '{8'd6,  ID_RESET, 3'd0, PC_RST};
      default:   r = '{8'd0,  8'd0,     3'd0, PC_START};
    endcase
    return r;
  endfunction

  function automatic uop_t ucode(input pc_t pc);
    uop_t u;
    unique case (pc)
      5'd0:    u = '{SRC_HDR0, 3'd0, MODE_SEQ,      3'd0, PC_START};
      5'd1:    u = '{SRC_HDR1, 3'd0, MODE_SEQ,      3'd0, PC_START};
      5'd2:    u = '{SRC_LEN,  3'd0, MODE_SEQ,      3'd0, PC_START};
      5'd3:    u = '{SRC_ID,   3'd0, MODE_DISPATCH, 3'd0, PC_START};
      5'd4:    u = '{SRC_WHI,  3'd0, MODE_SEQ,      3'd0, PC_START};
      5'd5:    u = '{SRC_WLO,  3'd0, MODE_BRANCH,   3'd1, PC_SUM};
      5'd6:    u = '{SRC_WHI,  3'd1, MODE_SEQ,      3'd0, PC_START};
      5'd7:    u = '{SRC_WLO,  3'd1, MODE_SEQ,      3'd0, PC_START};
      5'd8:    u = '{SRC_WHI,  3'd2, MODE_SEQ,      3'd0, PC_START};
      5'd9:    u = '{SRC_WLO,  3'd2, MODE_BRANCH,   3'd3, PC_SUM};
      5'd10:   u = '{SRC_WHI,  3'd3, MODE_SEQ,      3'd0, PC_START};
      5'd11:   u = '{SRC_WLO,  3'd3, MODE_SEQ,      3'd0, PC_START};
      5'd12:   u = '{SRC_WHI,  3'd4, MODE_SEQ,      3'd0, PC_START};
      5'd13:   u = '{SRC_WLO,  3'd4, MODE_BRANCH,   3'd5, PC_SUM};
      5'd14:   u = '{SRC_WHI,  3'd5, MODE_SEQ,      3'd0, PC_START};
      5'd15:   u = '{SRC_WLO,  3'd5, MODE_SEQ,      3'd0, PC_START};
      5'd16:   u = '{SRC_WHI,  3'd6, MODE_SEQ,      3'd0, PC_START};
      5'd17:   u = '{SRC_WLO,  3'd6, MODE_JUMP,     3'd0, PC_SUM};
      5'd18:   u = '{SRC_RST,  3'd0, MODE_SEQ,      3'd0, PC_START};
      default: u = '{SRC_SUM,  3'd0, MODE_SEQ,      3'd0, PC_START};
    endcase
    return u;
  endfunction

endpackage

/* rtl/core/command_frame_encoder.sv */
// Command frame encoder: input conversion, microcoded byte sequencer and output register.
// The command transfer sets busy_r; the first byte is then registered into out_byte_r.
// Throughput: one frame byte per cycle while out_ready stays high, set by the
// one-step-per-byte microcode sequencer (frames of 6 to 19 bytes, ik the longest).
// A new command transfers while the checksum byte of the previous frame still waits.
// Reset: synchronous active-low; clears sequencer and output valid, loads default limits.
module command_frame_encoder (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [14:0]        cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         in_cmd,
  input  logic signed [31:0] in_value_a,
  input  logic signed [31:0] in_value_b,
  input  logic signed [31:0] in_value_c,
  input  logic signed [31:0] in_value_d,
  input  logic signed [31:0] in_value_e,
  input  logic signed [31:0] in_value_f,
  input  logic signed [31:0] in_value_g,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         out_byte,
  output logic               out_last_byte
);

  function automatic logic [15:0] sat16(input logic signed [31:0] v);
    logic [15:0] r;
    if (v > 32'sd32767) begin
      r = 16'h7FFF;
    end else if (v < -32'sd32768) begin
      r = 16'h8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  function automatic logic [15:0] clamp_lim(input logic signed [31:0] v,
                                            input logic [14:0] lim);
    logic signed [31:0] lim_p;
    logic signed [31:0] lim_n;
    logic [15:0]        r;
    lim_p = $signed({17'd0, lim});
    lim_n = -lim_p;
    if (v > lim_p) begin
      r = {1'b0, lim};
    end else if (v < lim_n) begin
      r = lim_n[15:0];
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  function automatic logic [15:0] satu16(input logic signed [31:0] v);
    logic [15:0] r;
    if (v[31]) begin
      r = 16'h0000;
    end else if (|v[30:16]) begin
      r = 16'hFFFF;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  logic [14:0]         lim_x_r, lim_y_r, lim_w_r;
  logic                busy_r;
  cfe_pkg::pc_t        pc_r, pc_nxt;
  logic [7:0]          sum_r;
  cfe_pkg::cmd_info_t  info_r;
  logic [15:0]         held_words_r [7];
  logic                out_valid_r;
  logic [7:0]          out_byte_r;
  logic                out_last_r;

  cfe_pkg::cmd_info_t  in_info;
  logic                in_fire;
  logic                cmd_ok;
  logic                step;
  cfe_pkg::uop_t       uop;
  logic [15:0]         word_sel;
  logic [7:0]          byte_nxt;
  logic                is_vel;

  assign in_ready = !busy_r;
  assign in_fire  = in_valid && in_ready;
  assign in_info  = cfe_pkg::cmd_info(in_cmd);
  assign cmd_ok   = (in_cmd <= cfe_pkg::CMD_RESET);
  assign is_vel   = (in_cmd == cfe_pkg::CMD_VEL);

  assign step     = busy_r && (!out_valid_r || out_ready);
  assign uop      = cfe_pkg::ucode(pc_r);
  assign word_sel = held_words_r[uop.widx];

  always_comb begin
    unique case (uop.src)
      cfe_pkg::SRC_HDR0: byte_nxt = cfe_pkg::HDR0;
      cfe_pkg::SRC_HDR1: byte_nxt = cfe_pkg::HDR1;
      cfe_pkg::SRC_LEN:  byte_nxt = info_r.len;
      cfe_pkg::SRC_ID:   byte_nxt = info_r.id;
      cfe_pkg::SRC_WHI:  byte_nxt = word_sel[15:8];
      cfe_pkg::SRC_WLO:  byte_nxt = word_sel[7:0];
      cfe_pkg::SRC_RST:  byte_nxt = cfe_pkg::RESET_PAYLOAD;
      default:           byte_nxt = sum_r;
    endcase
  end

  always_comb begin
    pc_nxt = pc_r + cfe_pkg::pc_t'(1);
    unique case (uop.mode)
      cfe_pkg::MODE_DISPATCH: pc_nxt = info_r.entry;
      cfe_pkg::MODE_BRANCH: begin
        if (info_r.nwords == uop.cond) begin
          pc_nxt = uop.target;
        end
      end
      cfe_pkg::MODE_JUMP:     pc_nxt = uop.target;
      default:                pc_nxt = pc_r + cfe_pkg::pc_t'(1);
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lim_x_r <= cfe_pkg::LIM_X_RST;
      lim_y_r <= cfe_pkg::LIM_Y_RST;
      lim_w_r <= cfe_pkg::LIM_W_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        cfe_pkg::CFG_LIM_X: lim_x_r <= cfg_wdata;
        cfe_pkg::CFG_LIM_Y: lim_y_r <= cfg_wdata;
        cfe_pkg::CFG_LIM_W: lim_w_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      pc_r        <= cfe_pkg::PC_START;
      sum_r       <= 8'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire && cmd_ok) begin
        busy_r <= 1'b1;
        pc_r   <= cfe_pkg::PC_START;
        sum_r  <= 8'd0;
      end else if (step) begin
        pc_r  <= pc_nxt;
        sum_r <= sum_r + byte_nxt;
        if (uop.src == cfe_pkg::SRC_SUM) begin
          busy_r <= 1'b0;
        end
      end
      if (step) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && cmd_ok) begin
      info_r          <= in_info;
      held_words_r[0] <= is_vel ? clamp_lim(in_value_a, lim_x_r) : sat16(in_value_a);
      held_words_r[1] <= is_vel ? clamp_lim(in_value_b, lim_y_r) : sat16(in_value_b);
      held_words_r[2] <= is_vel ? clamp_lim(in_value_c, lim_w_r) : sat16(in_value_c);
      held_words_r[3] <= sat16(in_value_d);
      held_words_r[4] <= sat16(in_value_e);
      held_words_r[5] <= sat16(in_value_f);
      held_words_r[6] <= satu16(in_value_g);
    end
    if (step) begin
      out_byte_r <= byte_nxt;
      out_last_r <= (uop.src == cfe_pkg::SRC_SUM);
    end
  end

  assign out_valid     = out_valid_r;
  assign out_byte      = out_byte_r;
  assign out_last_byte = out_last_r;

endmodule
